>>> hdl/mbd_pkg.sv
// Shared types and fixed field widths for the multichannel block delay.
// No dependencies; compiled first.
`default_nettype none

package mbd_pkg;

    localparam int LANE_W    = 5;
    localparam int SAMPLE_W  = 32;
    localparam int DELAY_W   = 7;
    localparam int MAX_LANES = 32;   // reachable through the lane field

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_ELEM = 2'd1,
        CMD_SET  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        BS_CLEAR,
        BS_RUN,
        BS_HOLD
    } t_bstate;

endpackage

`default_nettype wire

>>> hdl/mbd_if.sv
// Valid/ready channel interfaces for request and result items.
// Depends on mbd_pkg for field widths.
`default_nettype none

interface mbd_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    cmd;
    logic [mbd_pkg::LANE_W-1:0]    lane;
    logic [mbd_pkg::SAMPLE_W-1:0]  sample;
    logic [mbd_pkg::DELAY_W-1:0]   delay;

    modport source (output valid, cmd, lane, sample, delay, input ready);
    modport sink   (input valid, cmd, lane, sample, delay, output ready);
endinterface

interface mbd_out_if;
    logic                          valid;
    logic                          ready;
    logic [mbd_pkg::LANE_W-1:0]    out_lane;
    logic [mbd_pkg::SAMPLE_W-1:0]  delayed_sample;

    modport source (output valid, out_lane, delayed_sample, input ready);
    modport sink   (input valid, out_lane, delayed_sample, output ready);
endinterface

`default_nettype wire

>>> hdl/mbd_front.sv
// Front end: accepts requests, owns read position and lane delays,
// resolves element requests into memory positions. Depends on mbd_pkg, mbd_if.
`default_nettype none

module mbd_front #(
    parameter int LANES = 32,
    parameter int DEPTH = 128,
    localparam int NL  = (LANES < mbd_pkg::MAX_LANES) ? LANES : mbd_pkg::MAX_LANES,
    localparam int LIW = (NL > 1) ? $clog2(NL) : 1,
    localparam int PW  = $clog2(DEPTH),
    localparam int QW  = LIW + mbd_pkg::SAMPLE_W + 2 * PW + 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    mbd_in_if.sink             i_in,
    input  wire logic          i_q_full,
    input  wire logic          i_clr_busy,
    output logic               o_push,
    output logic [QW-1:0]      o_entry
);

    logic [PW-1:0]                   r_rpos;
    logic [PW-1:0]                   n_rpos;
    logic [PW-1:0]                   r_delay [NL];
    logic                            accept;
    logic                            lane_ok;
    logic [LIW-1:0]                  lane_idx;
    logic [mbd_pkg::DELAY_W-1:0]     rem;
    logic [PW-1:0]                   d_red;
    logic [PW-1:0]                   d_cur;
    logic [PW:0]                     wsum;
    logic [PW-1:0]                   wpos;
    logic                            do_tick;
    logic                            do_set;

    assign i_in.ready = !i_q_full && !i_clr_busy;
    assign accept     = i_in.valid && i_in.ready;
    assign lane_ok    = (32'(i_in.lane) < NL);
    assign lane_idx   = i_in.lane[LIW-1:0];

    always_comb begin
        do_tick = 1'b0;
        do_set  = 1'b0;
        o_push  = 1'b0;
        unique case (mbd_pkg::t_cmd'(i_in.cmd))
            mbd_pkg::CMD_TICK: do_tick = accept;
            mbd_pkg::CMD_ELEM: o_push  = accept && lane_ok;
            mbd_pkg::CMD_SET:  do_set  = accept && lane_ok;
            default: ;
        endcase
    end

    // delay mod DEPTH by shifted compare-subtract, one step per delay bit
    always_comb begin
        rem = i_in.delay;
        for (int k = mbd_pkg::DELAY_W - 1; k >= 0; k--) begin
            if ((DEPTH << k) < (1 << mbd_pkg::DELAY_W)) begin
                if (32'(rem) >= (DEPTH << k)) begin
                    rem = rem - mbd_pkg::DELAY_W'(DEPTH << k);
                end
            end
        end
    end
    assign d_red = PW'(rem);

    assign d_cur = r_delay[lane_idx];
    assign wsum  = {1'b0, r_rpos} + {1'b0, d_cur};
    assign wpos  = (wsum >= (PW + 1)'(DEPTH)) ? PW'(wsum - (PW + 1)'(DEPTH)) : wsum[PW-1:0];

    assign n_rpos  = (r_rpos == PW'(DEPTH - 1)) ? '0 : r_rpos + 1'b1;
    assign o_entry = {lane_idx, i_in.sample, r_rpos, wpos, (d_cur == '0)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpos <= '0;
            for (int i = 0; i < NL; i++) begin
                r_delay[i] <= '0;
            end
        end else begin
            if (do_tick) begin
                r_rpos <= n_rpos;
            end
            if (do_set) begin
                r_delay[lane_idx] <= d_red;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/mbd_queue.sv
// Two-entry request queue between front end and memory sequencer.
// No package dependencies.
`default_nettype none

module mbd_queue #(
    parameter int W = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [W-1:0]  i_data,
    input  wire logic          i_pop,
    output logic [W-1:0]       o_head,
    output logic               o_full,
    output logic               o_empty
);

    logic [W-1:0] r_slot [2];
    logic         r_wr;
    logic         r_rd;
    logic [1:0]   r_cnt;
    logic         do_push;
    logic         do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_slot[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= !r_wr;
            end
            if (do_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/mbd_back.sv
// Memory sequencer: delay memory, post-reset clearing pass, result register.
// Depends on mbd_pkg and mbd_if.
`default_nettype none

module mbd_back #(
    parameter int LANES = 32,
    parameter int DEPTH = 128,
    localparam int NL  = (LANES < mbd_pkg::MAX_LANES) ? LANES : mbd_pkg::MAX_LANES,
    localparam int LIW = (NL > 1) ? $clog2(NL) : 1,
    localparam int PW  = $clog2(DEPTH),
    localparam int QW  = LIW + mbd_pkg::SAMPLE_W + 2 * PW + 1,
    localparam int MD  = NL * DEPTH,
    localparam int AW  = $clog2(MD)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [QW-1:0] i_head,
    input  wire logic          i_q_empty,
    output logic               o_pop,
    output logic               o_clr_busy,
    mbd_out_if.source          o_out
);

    mbd_pkg::t_bstate               r_state;
    mbd_pkg::t_bstate               n_state;
    logic [AW-1:0]                  r_clr_addr;
    logic [mbd_pkg::SAMPLE_W-1:0]   r_mem [MD];
    logic [mbd_pkg::SAMPLE_W-1:0]   r_rdata;
    logic [LIW-1:0]                 r_lane;
    logic [AW-1:0]                  r_raddr;
    logic                           r_ovalid;
    logic [LIW-1:0]                 r_olane;
    logic [mbd_pkg::SAMPLE_W-1:0]   r_odata;

    logic                           h_same;
    logic [PW-1:0]                  h_wpos;
    logic [PW-1:0]                  h_rpos;
    logic [mbd_pkg::SAMPLE_W-1:0]   h_sample;
    logic [LIW-1:0]                 h_lane;
    logic [AW:0]                    base;
    logic [AW-1:0]                  addr_r;
    logic [AW-1:0]                  addr_w;
    logic                           out_free;
    logic                           we;
    logic [AW-1:0]                  waddr;
    logic [mbd_pkg::SAMPLE_W-1:0]   wdata;
    logic                           re;
    logic                           load;
    logic [LIW-1:0]                 n_olane;
    logic [mbd_pkg::SAMPLE_W-1:0]   n_odata;

    assign h_same   = i_head[0];
    assign h_wpos   = i_head[PW:1];
    assign h_rpos   = i_head[2*PW:PW+1];
    assign h_sample = i_head[2*PW+mbd_pkg::SAMPLE_W:2*PW+1];
    assign h_lane   = i_head[QW-1:QW-LIW];

    assign base   = (AW + 1)'(h_lane) * (AW + 1)'(DEPTH);
    assign addr_r = base[AW-1:0] + AW'(h_rpos);
    assign addr_w = base[AW-1:0] + AW'(h_wpos);

    assign out_free   = !r_ovalid || o_out.ready;
    assign o_clr_busy = (r_state == mbd_pkg::BS_CLEAR);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mbd_pkg::BS_CLEAR: begin
                if (r_clr_addr == AW'(MD - 1)) begin
                    n_state = mbd_pkg::BS_RUN;
                end
            end
            mbd_pkg::BS_RUN: begin
                if (!i_q_empty && !h_same) begin
                    n_state = mbd_pkg::BS_HOLD;
                end
            end
            mbd_pkg::BS_HOLD: begin
                if (out_free) begin
                    n_state = mbd_pkg::BS_RUN;
                end
            end
            default: n_state = mbd_pkg::BS_CLEAR;
        endcase
    end

    // Nonzero delay: read old word and write sample, then clear the read slot.
    // Zero delay: the sample is its own result and the slot is cleared at once.
    always_comb begin
        we      = 1'b0;
        waddr   = r_clr_addr;
        wdata   = '0;
        re      = 1'b0;
        o_pop   = 1'b0;
        load    = 1'b0;
        n_olane = h_lane;
        n_odata = h_sample;
        unique case (r_state)
            mbd_pkg::BS_CLEAR: begin
                we = 1'b1;
            end
            mbd_pkg::BS_RUN: begin
                if (!i_q_empty) begin
                    if (h_same) begin
                        if (out_free) begin
                            o_pop = 1'b1;
                            we    = 1'b1;
                            waddr = addr_r;
                            load  = 1'b1;
                        end
                    end else begin
                        o_pop = 1'b1;
                        we    = 1'b1;
                        waddr = addr_w;
                        wdata = h_sample;
                        re    = 1'b1;
                    end
                end
            end
            mbd_pkg::BS_HOLD: begin
                if (out_free) begin
                    we      = 1'b1;
                    waddr   = r_raddr;
                    load    = 1'b1;
                    n_olane = r_lane;
                    n_odata = r_rdata;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mbd_pkg::BS_CLEAR;
            r_clr_addr <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == mbd_pkg::BS_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= r_mem[addr_r];
            r_lane  <= h_lane;
            r_raddr <= addr_r;
        end
        if (load) begin
            r_olane <= n_olane;
            r_odata <= n_odata;
        end
    end

    assign o_out.valid          = r_ovalid;
    assign o_out.out_lane       = mbd_pkg::LANE_W'(r_olane);
    assign o_out.delayed_sample = r_odata;

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_q_empty)
        else $error("pop from empty queue");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mbd_pkg::BS_CLEAR) |-> (!r_ovalid && !o_pop))
        else $error("activity during clearing pass");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mbd_pkg::BS_HOLD && out_free) |=>
        (r_ovalid && r_state == mbd_pkg::BS_RUN))
        else $error("held element did not deliver its result");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == mbd_pkg::BS_CLEAR && r_clr_addr == '0))
        else $error("reset did not restart clearing pass");

endmodule

`default_nettype wire

>>> hdl/multichannel_block_delay.sv
// Top level of the multichannel block delay: front end, queue, memory sequencer.
// Depends on mbd_pkg, mbd_if, mbd_front, mbd_queue, mbd_back.
`default_nettype none

// Bank of per-lane circular delay lines sharing one read position, held in a
// single memory of min(LANES,32)*DEPTH words. After reset the memory is zeroed
// by a clearing pass over every word, during which no request is taken. An
// element request whose lane delay (mod DEPTH) is nonzero reads the old word
// while writing the sample, then clears the read slot, as the memory has a
// single write port; at zero delay the sample is its own result and the slot
// is cleared at once. A two-entry queue and a result register let requests
// keep arriving while a result waits to be taken. Lane indexes of LANES or
// more are ignored.
module multichannel_block_delay #(
    parameter int LANES = 32,
    parameter int DEPTH = 128
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mbd_in_if.sink     i_in,
    mbd_out_if.source  o_out
);

    localparam int NL  = (LANES < mbd_pkg::MAX_LANES) ? LANES : mbd_pkg::MAX_LANES;
    localparam int LIW = (NL > 1) ? $clog2(NL) : 1;
    localparam int PW  = $clog2(DEPTH);
    localparam int QW  = LIW + mbd_pkg::SAMPLE_W + 2 * PW + 1;

    logic          push;
    logic [QW-1:0] entry;
    logic          pop;
    logic [QW-1:0] head;
    logic          q_full;
    logic          q_empty;
    logic          clr_busy;

    mbd_front #(.LANES(LANES), .DEPTH(DEPTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .i_clr_busy (clr_busy),
        .o_push     (push),
        .o_entry    (entry)
    );

    mbd_queue #(.W(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    mbd_back #(.LANES(LANES), .DEPTH(DEPTH)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_empty  (q_empty),
        .o_pop      (pop),
        .o_clr_busy (clr_busy),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

>>> tb/mbd_delay_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the multichannel block delay: keeps its own copy of the lane
// delay lines, predicts every result request and compares it. Uses mbd_pkg, mbd_if.
module mbd_delay_checker #(
    parameter int LANES = 32,
    parameter int DEPTH = 128
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mbd_in_if    i_req,
    mbd_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);
    import mbd_pkg::*;

    typedef struct packed {
        logic [LANE_W-1:0]   lane;
        logic [SAMPLE_W-1:0] word;
    } t_delayed_word;

    t_delayed_word       expected_words[$];
    int                  read_pos;
    logic [DELAY_W-1:0]  lane_delay [LANES];
    logic [SAMPLE_W-1:0] line_mem   [LANES][DEPTH];
    int                  fails;
    int                  ln;
    int                  pos;

    task automatic predict_delayed_word();
        int            slot;
        t_delayed_word res;
        if (i_req.cmd == CMD_TICK) begin
            read_pos = (read_pos + 1) % DEPTH;
        end else if (i_req.cmd == CMD_ELEM && i_req.lane < LANES) begin
            // write first, then read and clear: zero delay passes straight through
            slot = (read_pos + (lane_delay[i_req.lane] % DEPTH)) % DEPTH;
            line_mem[i_req.lane][slot] = i_req.sample;
            res.lane = i_req.lane;
            res.word = line_mem[i_req.lane][read_pos];
            line_mem[i_req.lane][read_pos] = '0;
            expected_words.push_back(res);
        end else if (i_req.cmd == CMD_SET && i_req.lane < LANES) begin
            lane_delay[i_req.lane] = i_req.delay;
        end
    endtask

    task automatic compare_result();
        t_delayed_word exp_word;
        if (expected_words.size() == 0) begin
            $display("%0t: result with none expected: lane %0d word %h", $time,
                     i_res.out_lane, i_res.delayed_sample);
            fails++;
        end else begin
            exp_word = expected_words.pop_front();
            if (i_res.out_lane !== exp_word.lane) begin
                $display("%0t: out_lane mismatch: expected %0d actual %0d", $time,
                         exp_word.lane, i_res.out_lane);
                fails++;
            end
            if (i_res.delayed_sample !== exp_word.word) begin
                $display("%0t: delayed_sample mismatch (lane %0d): expected %h actual %h",
                         $time, exp_word.lane, exp_word.word, i_res.delayed_sample);
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            read_pos = 0;
            fails    = 0;
            expected_words.delete();
            for (ln = 0; ln < LANES; ln++) begin
                lane_delay[ln] = '0;
                for (pos = 0; pos < DEPTH; pos++) line_mem[ln][pos] = '0;
            end
        end else begin
            if (i_res.valid && i_res.ready) compare_result();
            if (i_req.valid && i_req.ready) predict_delayed_word();
        end
        o_fail_count <= fails;
        o_pending    <= expected_words.size();
    end

endmodule

>>> tb/tb_multichannel_block_delay.sv
`timescale 1ns / 1ps
// Top of the multichannel block delay testbench: clock, reset, request stimulus,
// result drain and verdict. Uses mbd_pkg, mbd_if, mbd_delay_checker and the RTL.
module tb_multichannel_block_delay;
    import mbd_pkg::*;

    localparam int         LANES        = 32;
    localparam int         DEPTH        = 128;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 400;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         DRAIN_CYCLES = 20;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   calm_stretch;
    bit   hold_results;

    mbd_in_if  in_ch ();
    mbd_out_if out_ch ();

    multichannel_block_delay #(
        .LANES (LANES),
        .DEPTH (DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    mbd_delay_checker #(
        .LANES (LANES),
        .DEPTH (DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (in_ch),
        .i_res        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #1 i_clk = ~i_clk;

    // covers the clearing pass after reset with wide margin
    initial begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin : result_drain
        int held;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_results) begin
                out_ch.ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(posedge i_clk);
                hold_results = 1'b0;
            end else begin
                out_ch.ready <= calm_stretch || ($urandom_range(99) >= 7);
                @(posedge i_clk);
            end
        end
    end

    // valid stays high across back-to-back requests; lowered only for a gap
    task automatic send_request(input logic [1:0] cmd, input logic [LANE_W-1:0] lane,
                                input logic [SAMPLE_W-1:0] sample,
                                input logic [DELAY_W-1:0] delay);
        if (!calm_stretch && $urandom_range(99) < 7) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.cmd    <= cmd;
        in_ch.lane   <= lane;
        in_ch.sample <= sample;
        in_ch.delay  <= delay;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin : stimulus
        int                  sent;
        int                  pick;
        bit                  hold_done;
        bit                  pause_done;
        logic [LANE_W-1:0]   lane;
        logic [DELAY_W-1:0]  delay;

        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.cmd    <= CMD_TICK;
        in_ch.lane   <= '0;
        in_ch.sample <= '0;
        in_ch.delay  <= '0;
        calm_stretch = 1'b0;
        hold_results = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: passthrough, one-frame delay, longest delay, unused command
        send_request(CMD_ELEM,   5'd0,  32'hFFFF_FFFF, 7'd0);
        send_request(CMD_ELEM,   5'd31, 32'h0000_0000, 7'd0);
        send_request(CMD_SET,    5'd1,  32'h0,         7'd1);
        send_request(CMD_ELEM,   5'd1,  32'hA5A5_A5A5, 7'd0);
        send_request(CMD_TICK,   5'd0,  32'h0,         7'd0);
        send_request(CMD_ELEM,   5'd1,  32'h5A5A_5A5A, 7'd0);
        send_request(CMD_SET,    5'd31, 32'h0,         7'd127);
        send_request(CMD_ELEM,   5'd31, 32'h1234_5678, 7'd0);
        send_request(CMD_UNUSED, 5'd31, 32'hFFFF_FFFF, 7'd127);
        send_request(CMD_SET,    5'd2,  32'h0,         7'd85);
        send_request(CMD_SET,    5'd3,  32'h0,         7'd42);
        send_request(CMD_ELEM,   5'd2,  32'hDEAD_BEEF, 7'd0);
        send_request(CMD_ELEM,   5'd3,  32'h8000_0001, 7'd0);
        send_request(CMD_TICK,   5'd31, 32'hFFFF_FFFF, 7'd127);
        send_request(CMD_ELEM,   5'd1,  32'h0000_0000, 7'd0);
        send_request(CMD_ELEM,   5'd2,  32'h7FFF_FFFF, 7'd0);
        send_request(CMD_SET,    5'd1,  32'h0,         7'd0);
        send_request(CMD_SET,    5'd31, 32'h0,         7'd0);
        send_request(CMD_ELEM,   5'd31, 32'hFFFF_FFFF, 7'd0);
        send_request(CMD_ELEM,   5'd1,  32'h0F0F_F0F0, 7'd0);
        wait_results_drained();

        sent       = 0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            calm_stretch = (sent >= 60 && sent < 120);
            if (!hold_done && sent >= 150) begin
                hold_results = 1'b1;
                hold_done    = 1'b1;
            end
            if (!pause_done && sent >= 280) begin
                wait_results_drained();
                pause_done = 1'b1;
            end
            // a few busy lanes keep delayed words coming back
            lane = ($urandom_range(99) < 80) ? LANE_W'($urandom_range(3)) : LANE_W'($urandom);
            pick = $urandom_range(99);
            if (pick < 35) begin
                send_request(CMD_TICK, LANE_W'($urandom), $urandom, DELAY_W'($urandom));
                sent++;
            end else if (pick < 80) begin
                send_request(CMD_ELEM, lane, $urandom, DELAY_W'($urandom));
                sent++;
            end else if (pick < 95) begin
                case ($urandom_range(9))
                    0:       delay = '0;
                    1:       delay = '1;
                    2, 3:    delay = DELAY_W'($urandom);
                    default: delay = DELAY_W'($urandom_range(6));
                endcase
                send_request(CMD_SET, lane, $urandom, delay);
                sent++;
            end else begin
                send_request(CMD_UNUSED, LANE_W'($urandom), $urandom, DELAY_W'($urandom));
            end
        end
        calm_stretch = 1'b0;

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
